/* rtl/rgba_mip_pkg.sv */
// Shared types and constants for the RGBA8 box-filter mip downsampler.
`timescale 1ns / 1ps

package rgba_mip_pkg;

    // source dimensions are clamped to 1..DIM_MAX
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned CNT_W     = 12;
    localparam int unsigned DIM_MAX   = 4096;

    // default line capacity in source pixels
    localparam int unsigned MAX_WIDTH_DEF = 4096;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;

    localparam int unsigned CHAN_N   = 4;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned SUM_W    = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH    = 3'd0,
        CFG_SRC_HEIGHT   = 3'd1,
        CFG_HALVE_WIDTH  = 3'd2,
        CFG_HALVE_HEIGHT = 3'd3,
        CFG_VOLUME_MODE  = 3'd4
    } t_cfg_reg;

    // four 10-bit channel sums, R in the lowest field
    typedef logic [CHAN_N-1:0][SUM_W-1:0]  t_quad_sum;
    // RGBA8 pixel, R in the lowest byte
    typedef logic [CHAN_N-1:0][CHAN_W-1:0] t_pixel;

    // clamp a configured dimension to 1..DIM_MAX
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(DIM_MAX)) begin
            r = DIM_W'(DIM_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/rgba8_box_filter_mip_downsample.sv */
// Top level: streaming 2x2 (or 2x2x2) box-filter mip downsampler for RGBA8.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one item per source pixel in raster order; tdata carries the
//   first-slice pixel in bits 31:0 and the second-slice pixel in 63:32.
//   Master stream: one item per destination pixel; tdata is the averaged RGBA8
//   pixel, tlast marks the final destination pixel of the frame.
//   Config port: write src_width, src_height, halve_width, halve_height and
//   volume_mode by index while the block is idle. Sizes are clamped to 1..4096.
//   Pipeline: accept -> pair stage -> line store read -> output register.
//   tvalid rises once an item has moved through the pair stage and the line
//   store read into the output register; one item per clock is sustained while
//   the master side takes results, the line store being written or read at most once per item.
//   Even-row pair sums are parked in the line store (MAX_WIDTH/2 entries) until
//   the odd row arrives; trailing odd columns and rows are consumed silently.
//   Reset (synchronous, active low) clears the counters, the pipeline valid
//   bits and restores default config; the line store is not cleared, as every
//   entry is written before its value is used.
//   Stalls: each stage moves on when the next one is empty or moving, so the
//   input keeps being taken while bubbles remain behind a held result; with all
//   three stages holding results and tready low, tready on the slave side drops.
module rgba8_box_filter_mip_downsample #(
    parameter int unsigned MAX_WIDTH = rgba_mip_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // pixel_first_slice [31:0], pixel_second_slice [63:32]

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // mip_pixel [31:0]
    output logic        o_m_axis_tlast,   // last_of_frame

    input  logic                                i_cfg_we,
    input  logic [rgba_mip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgba_mip_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned Depth = MAX_WIDTH / 2;
    localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned DimW  = rgba_mip_pkg::DIM_W;
    localparam int unsigned CntW  = rgba_mip_pkg::CNT_W;

    // ---------------- configuration ----------------
    logic [DimW-1:0] r_src_width;
    logic [DimW-1:0] r_src_height;
    logic            r_halve_w;
    logic            r_halve_h;
    logic            r_volume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DimW'(2);
            r_src_height <= DimW'(2);
            r_halve_w    <= 1'b1;
            r_halve_h    <= 1'b1;
            r_volume     <= 1'b0;
        end else if (i_cfg_we) begin
            case (rgba_mip_pkg::t_cfg_reg'(i_cfg_index))
                rgba_mip_pkg::CFG_SRC_WIDTH:    r_src_width  <= i_cfg_data[DimW-1:0];
                rgba_mip_pkg::CFG_SRC_HEIGHT:   r_src_height <= i_cfg_data[DimW-1:0];
                rgba_mip_pkg::CFG_HALVE_WIDTH:  r_halve_w    <= i_cfg_data[0];
                rgba_mip_pkg::CFG_HALVE_HEIGHT: r_halve_h    <= i_cfg_data[0];
                rgba_mip_pkg::CFG_VOLUME_MODE:  r_volume     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- handshakes / stage enables ----------------
    logic r_a_valid, r_a_out, r_a_wr;
    logic r_b_valid;
    logic r_c_valid;
    logic c_en, b_en, a_en;
    logic in_acc;

    assign c_en   = !r_c_valid || i_m_axis_tready;
    assign b_en   = !r_b_valid || c_en;
    // write-only items leave the pair stage without entering the read stage
    assign a_en   = !r_a_valid || !r_a_out || b_en;
    assign in_acc = i_s_axis_tvalid && a_en;

    assign o_s_axis_tready = a_en;

    // ---------------- position tracking ----------------
    logic [CntW-1:0] r_col, r_row;
    logic [IdxW-1:0] r_idx_full;      // column modulo the line store depth
    logic [IdxW-1:0] r_idx_half;      // column pair modulo the line store depth
    logic [IdxW-1:0] store_idx;       // dc modulo the line store depth
    rgba_mip_pkg::t_quad_sum r_acc;   // even-column channel sums

    logic [DimW-1:0] w, h, dw, dh;
    logic [CntW-1:0] dc, dr;
    logic            col_wrap, row_wrap, in_range, pair_done, is_last;
    rgba_mip_pkg::t_pixel    px_a, px_b;
    rgba_mip_pkg::t_quad_sum s_sum, pair;

    always_comb begin
        w  = rgba_mip_pkg::clamp_dim(r_src_width);
        h  = rgba_mip_pkg::clamp_dim(r_src_height);
        dw = r_halve_w ? (w >> 1) : w;
        dh = r_halve_h ? (h >> 1) : h;
        dc = r_halve_w ? (r_col >> 1) : r_col;
        dr = r_halve_h ? (r_row >> 1) : r_row;
        store_idx = r_halve_w ? r_idx_half : r_idx_full;

        col_wrap = ({1'b0, r_col} + DimW'(1)) >= w;
        row_wrap = ({1'b0, r_row} + DimW'(1)) >= h;

        in_range  = ({1'b0, dc} < dw) && ({1'b0, dr} < dh);
        pair_done = in_range && (!r_halve_w || r_col[0]);
        is_last   = (({1'b0, dc} + DimW'(1)) == dw) && (({1'b0, dr} + DimW'(1)) == dh);

        px_a = i_s_axis_tdata[31:0];
        px_b = i_s_axis_tdata[63:32];
        for (int c = 0; c < rgba_mip_pkg::CHAN_N; c++) begin
            s_sum[c] = {2'b00, px_a[c]} + (r_volume ? {2'b00, px_b[c]} : '0);
            if (!r_halve_w) begin
                pair[c] = {s_sum[c][rgba_mip_pkg::SUM_W-2:0], 1'b0};
            end else begin
                pair[c] = r_acc[c] + s_sum[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_idx_full <= '0;
            r_idx_half <= '0;
            r_acc      <= '0;
        end else if (in_acc) begin
            if (in_range && r_halve_w && !r_col[0]) begin
                r_acc <= s_sum;
            end
            if (col_wrap) begin
                r_col      <= '0;
                r_row      <= row_wrap ? '0 : r_row + CntW'(1);
                r_idx_full <= '0;
                r_idx_half <= '0;
            end else begin
                r_col      <= r_col + CntW'(1);
                r_idx_full <= (r_idx_full == IdxW'(Depth - 1)) ? '0
                                                               : r_idx_full + IdxW'(1);
                if (r_col[0]) begin
                    r_idx_half <= (r_idx_half == IdxW'(Depth - 1)) ? '0
                                                                   : r_idx_half + IdxW'(1);
                end
            end
        end
    end

    // ---------------- stage A: pair sums ----------------
    rgba_mip_pkg::t_quad_sum r_a_pair;
    logic [IdxW-1:0]         r_a_idx;
    logic                    r_a_last, r_a_hh, r_a_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_en) begin
            r_a_valid <= in_acc && pair_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en) begin
            r_a_out  <= !(r_halve_h && !r_row[0]);
            r_a_wr   <= r_halve_h && !r_row[0];
            r_a_pair <= pair;
            r_a_idx  <= store_idx;
            r_a_last <= is_last;
            r_a_hh   <= r_halve_h;
            r_a_vol  <= r_volume;
        end
    end

    // ---------------- line store ----------------
    logic [rgba_mip_pkg::CHAN_N*rgba_mip_pkg::SUM_W-1:0] r_store [Depth];
    rgba_mip_pkg::t_quad_sum r_b_mem;
    logic store_we, store_re;

    assign store_we = r_a_valid && r_a_wr;
    assign store_re = b_en && r_a_valid && r_a_out;

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_a_idx] <= r_a_pair;
        end
        if (store_re) begin
            r_b_mem <= r_store[r_a_idx];
        end
    end

    // ---------------- stage B: vertical pair ----------------
    rgba_mip_pkg::t_quad_sum r_b_pair;
    logic                    r_b_last, r_b_hh, r_b_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_en) begin
            r_b_valid <= r_a_valid && r_a_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b_pair <= r_a_pair;
            r_b_last <= r_a_last;
            r_b_hh   <= r_a_hh;
            r_b_vol  <= r_a_vol;
        end
    end

    // rounded mean: (sum+2)/4, or (sum+4)/8 with the second slice
    rgba_mip_pkg::t_pixel n_c_pixel;
    logic [rgba_mip_pkg::SUM_W:0] vsum, vrnd;

    always_comb begin
        vsum = '0;
        vrnd = '0;
        for (int c = 0; c < rgba_mip_pkg::CHAN_N; c++) begin
            vsum = {1'b0, r_b_pair[c]} + {1'b0, (r_b_hh ? r_b_mem[c] : r_b_pair[c])};
            vrnd = r_b_vol ? ((vsum + 11'd4) >> 3) : ((vsum + 11'd2) >> 2);
            n_c_pixel[c] = vrnd[rgba_mip_pkg::CHAN_W-1:0];
        end
    end

    // ---------------- stage C: output register ----------------
    rgba_mip_pkg::t_pixel r_c_pixel;
    logic                 r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_c_pixel <= n_c_pixel;
            r_c_last  <= r_b_last;
        end
    end

    assign o_m_axis_tvalid = r_c_valid;
    assign o_m_axis_tdata  = r_c_pixel;
    assign o_m_axis_tlast  = r_c_last;

    // ---------------- checks ----------------
    // an empty output register never holds back the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_c_valid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

    // an item that yields no result must be an even-row store write
    a_silent_item_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a_out) |-> r_a_wr)
        else $error("pair stage item neither written nor forwarded");

    // reset empties the output
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

/* sim/rgba8_box_filter_mip_downsample_tb.sv */
// Self-checking testbench for the RGBA8 box-filter mip downsampler.
`timescale 1ns / 1ps

module rgba8_box_filter_mip_downsample_tb;

    // line store depth at the default line capacity
    localparam int unsigned ROW_STORE_DEPTH = rgba_mip_pkg::MAX_WIDTH_DEF / 2;
    // cycles with no item moving on either side before the run is abandoned
    localparam int unsigned STALL_LIMIT     = 1000;
    // settle time after the last expected result
    localparam int unsigned SETTLE_CYCLES   = 8;
    // source items sent by the random frames test
    localparam int unsigned RANDOM_ITEMS    = 680;

    // expected destination pixel and its end-of-frame flag
    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
    } t_mip_result;

    // ------------------------------------------------------------------
    // DUT connections, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [63:0]                         i_s_axis_tdata  = '0;  // pixel_first_slice [31:0], pixel_second_slice [63:32]
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [31:0]                         o_m_axis_tdata;        // mip_pixel [31:0]
    logic                                o_m_axis_tlast;        // last_of_frame
    logic                                i_cfg_we        = 1'b0;
    logic [rgba_mip_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [rgba_mip_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;

    rgba8_box_filter_mip_downsample dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers, counters and store.
    // Register copies hold the raw written values; sizes are clamped on use.
    // ------------------------------------------------------------------
    logic [rgba_mip_pkg::DIM_W-1:0] cfg_width    = rgba_mip_pkg::DIM_W'(2);
    logic [rgba_mip_pkg::DIM_W-1:0] cfg_height   = rgba_mip_pkg::DIM_W'(2);
    bit                             cfg_halve_w  = 1'b1;
    bit                             cfg_halve_h  = 1'b1;
    bit                             cfg_volume   = 1'b0;

    int unsigned                    col_pos      = 0;
    int unsigned                    row_pos      = 0;
    rgba_mip_pkg::t_quad_sum        pair_sum_acc = '0;
    rgba_mip_pkg::t_quad_sum        row_pair_sums [ROW_STORE_DEPTH];

    t_mip_result                    mip_expected_q [$];
    int unsigned                    faults       = 0;
    bit                             steady       = 1'b0;   // no idling on either side while set

    function automatic int unsigned fit_dim(input logic [rgba_mip_pkg::DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > rgba_mip_pkg::DIM_W'(rgba_mip_pkg::DIM_MAX)) begin
            return rgba_mip_pkg::DIM_MAX;
        end
        return int'(v);
    endfunction

    // gap length: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // random pixel pair; every so often saturated bytes to stress rounding and carry
    function automatic logic [63:0] random_pixels();
        logic [63:0] d;
        int          b;
        d = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) begin
            for (b = 0; b < 8; b++) begin
                d[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        end
        return d;
    endfunction

    function automatic void note_fault(input string msg);
        faults++;
        if (faults <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    // ------------------------------------------------------------------
    // Predictor: one accepted source item -> zero or one destination pixel
    // ------------------------------------------------------------------
    task automatic predict_mip_pixel(input logic [63:0] pixels);
        int unsigned             w, h, dw, dh, dc, dr, idx, c, a, b, total, mean;
        rgba_mip_pkg::t_pixel    first_px, second_px, mip_px;
        rgba_mip_pkg::t_quad_sum slice_sum, pair_sum;
        bit                      pair_ready;
        t_mip_result             res;

        w  = fit_dim(cfg_width);
        h  = fit_dim(cfg_height);
        dw = cfg_halve_w ? (w >> 1) : w;
        dh = cfg_halve_h ? (h >> 1) : h;
        dc = cfg_halve_w ? (col_pos >> 1) : col_pos;
        dr = cfg_halve_h ? (row_pos >> 1) : row_pos;
        first_px   = pixels[31:0];
        second_px  = pixels[63:32];
        pair_sum   = '0;
        pair_ready = 1'b0;

        // per-channel slice sum; second slice only counts in volume mode
        for (c = 0; c < rgba_mip_pkg::CHAN_N; c++) begin
            slice_sum[c] = rgba_mip_pkg::SUM_W'(first_px[c])
                         + (cfg_volume ? rgba_mip_pkg::SUM_W'(second_px[c]) : '0);
        end

        if (dc < dw && dr < dh) begin
            if (!cfg_halve_w) begin
                // column reused: double each channel
                for (c = 0; c < rgba_mip_pkg::CHAN_N; c++) begin
                    pair_sum[c] = slice_sum[c] << 1;
                end
                pair_ready = 1'b1;
            end else if ((col_pos & 1) == 0) begin
                pair_sum_acc = slice_sum;
            end else begin
                for (c = 0; c < rgba_mip_pkg::CHAN_N; c++) begin
                    pair_sum[c] = pair_sum_acc[c] + slice_sum[c];
                end
                pair_ready = 1'b1;
            end
        end

        if (pair_ready) begin
            idx = dc % ROW_STORE_DEPTH;
            if (cfg_halve_h && (row_pos & 1) == 0) begin
                // even row: park the pair until the odd row comes
                row_pair_sums[idx] = pair_sum;
            end else begin
                for (c = 0; c < rgba_mip_pkg::CHAN_N; c++) begin
                    a     = pair_sum[c];
                    b     = cfg_halve_h ? row_pair_sums[idx][c] : a;
                    total = a + b;
                    mean  = cfg_volume ? ((total + 4) >> 3) : ((total + 2) >> 2);
                    mip_px[c] = mean[7:0];
                end
                res.pixel = mip_px;
                res.last  = (dc == dw - 1) && (dr == dh - 1);
                mip_expected_q.push_back(res);
            end
        end

        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Source side: send one item, optionally after a gap; tvalid stays high
    // across back-to-back items so it never toggles within one step
    // ------------------------------------------------------------------
    task automatic push_source_pixel(input logic [63:0] pixels);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pixels;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_mip_pixel(pixels);
    endtask

    // one whole frame at the current sizes, so the counters end back at zero
    task automatic send_frame();
        int unsigned n;
        n = fit_dim(cfg_width) * fit_dim(cfg_height);
        repeat (n) push_source_pixel(random_pixels());
    endtask

    // stop sending, let every expected pixel out, then let silent items settle
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (mip_expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input rgba_mip_pkg::t_cfg_reg idx,
                             input logic [rgba_mip_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            rgba_mip_pkg::CFG_SRC_WIDTH:    cfg_width   = value;
            rgba_mip_pkg::CFG_SRC_HEIGHT:   cfg_height  = value;
            rgba_mip_pkg::CFG_HALVE_WIDTH:  cfg_halve_w = value[0];
            rgba_mip_pkg::CFG_HALVE_HEIGHT: cfg_halve_h = value[0];
            rgba_mip_pkg::CFG_VOLUME_MODE:  cfg_volume  = value[0];
            default: ;
        endcase
    endtask

    // full register set, only once the block is idle; flag registers get
    // random upper data bits, which must be ignored
    task automatic configure(input int unsigned w, input int unsigned h,
                             input bit hw, input bit hh, input bit vol);
        wait_drained();
        write_reg(rgba_mip_pkg::CFG_SRC_WIDTH,    rgba_mip_pkg::CFG_DATA_W'(w));
        write_reg(rgba_mip_pkg::CFG_SRC_HEIGHT,   rgba_mip_pkg::CFG_DATA_W'(h));
        write_reg(rgba_mip_pkg::CFG_HALVE_WIDTH,  {12'($urandom), hw});
        write_reg(rgba_mip_pkg::CFG_HALVE_HEIGHT, {12'($urandom), hh});
        write_reg(rgba_mip_pkg::CFG_VOLUME_MODE,  {12'($urandom), vol});
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset config (2x2, halving both ways): saturated frame, then rounding
    // edges with a non-zero second slice that must be ignored
    task automatic test_reset_defaults();
        repeat (4) push_source_pixel({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        push_source_pixel({32'hFFFF_FFFF, 32'h0000_0201});
        repeat (3) push_source_pixel({32'hFFFF_FFFF, 32'h0000_0000});
    endtask

    // eight-way mean: saturated frame, then channel sums of 4, right at the round point
    task automatic test_volume_mean();
        configure(2, 2, 1'b1, 1'b1, 1'b1);
        repeat (4) push_source_pixel({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        push_source_pixel({32'h0000_0203, 32'h0000_0201});
        repeat (3) push_source_pixel({32'h0000_0000, 32'h0000_0000});
    endtask

    // no halving, halving one way only, trailing odd column and row,
    // and a halved size of one that gives nothing at all
    task automatic test_halving_modes();
        configure(2, 2, 1'b0, 1'b0, 1'b0);
        send_frame();
        configure(3, 2, 1'b1, 1'b0, 1'b1);
        send_frame();
        configure(3, 3, 1'b1, 1'b1, 1'b0);
        send_frame();
        configure(1, 1, 1'b1, 1'b1, 1'b1);
        send_frame();
    endtask

    // smallest sizes: zero width and height clamp to one, and a tall single column
    task automatic test_size_extremes();
        configure(0, 0, 1'b0, 1'b0, 1'b1);
        send_frame();
        configure(0, 5, 1'b0, 1'b1, 1'b0);
        send_frame();
        configure(2, 0, 1'b1, 1'b0, 1'b1);
        send_frame();
        configure(1, 24, 1'b0, 1'b1, 1'b0);
        send_frame();
    endtask

    // mostly small random frames under random settings
    task automatic test_random_frames();
        int unsigned sent, w, h, frames;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 8);
            configure(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            frames = $urandom_range(1, 3);
            repeat (frames) send_frame();
            sent += frames * fit_dim(rgba_mip_pkg::CFG_DATA_W'(w))
                           * fit_dim(rgba_mip_pkg::CFG_DATA_W'(h));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_volume_mean();
        test_halving_modes();
        test_size_extremes();
        test_random_frames();
        wait_drained();
        if (faults == 0 && mip_expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side back-pressure: random stalls of mixed length
    initial begin : sink_stalls
        int unsigned hold;
        forever begin
            hold = pick_gap();
            if (hold != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // spells with no idling on either side
    initial begin : calm_spells
        forever begin
            repeat ($urandom_range(100, 500)) @(posedge i_clk);
            steady <= ($urandom_range(0, 3) == 0);
        end
    end

    // every accepted result against the oldest expectation, field by field
    initial begin : result_check
        t_mip_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (mip_expected_q.size() == 0) begin
                    note_fault($sformatf("unexpected mip pixel %h last %b",
                                         o_m_axis_tdata, o_m_axis_tlast));
                end else begin
                    want = mip_expected_q.pop_front();
                    if (o_m_axis_tdata !== want.pixel) begin
                        note_fault($sformatf("mip pixel: expected %h, got %h",
                                             want.pixel, o_m_axis_tdata));
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        note_fault($sformatf("last of frame: expected %b, got %b",
                                             want.last, o_m_axis_tlast));
                    end
                end
            end
        end
    end

    // abandon the run if nothing moves on either side for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
